// File: hdl/wmf_pkg.sv
// wmf_pkg: item types, register indexes and reset values of the window median filter
// no dependencies; imported by every module of the filter
`timescale 1ns / 1ps
`default_nettype none

package wmf_pkg;

  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 3 * CH_W;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_WINDOW_RADIUS = 2'd2,
    REG_COLOR_MODE    = 2'd3
  } cfg_idx_e;

  localparam logic [10:0] RST_FRAME_WIDTH   = 11'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [1:0]  RST_WINDOW_RADIUS = 2'd1;
  localparam logic        RST_COLOR_MODE    = 1'b0;

  typedef struct packed {
    logic            flush;
    logic [CH_W-1:0] chan0;
    logic [CH_W-1:0] chan1;
    logic [CH_W-1:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] med0;
    logic [CH_W-1:0] med1;
    logic [CH_W-1:0] med2;
    logic            frame_last;
  } res_item_t;

endpackage

`default_nettype wire

// File: hdl/wmf_front.sv
// wmf_front: configuration registers, input/output raster positions, line store writes
// and issue of window jobs; depends on wmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WB = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int HB = $clog2(MAX_HEIGHT + 1),
  localparam int RB = $clog2(MAX_RADIUS + 1),
  localparam int LS = 2 * MAX_RADIUS + 2,
  localparam int SW = $clog2(LS),
  localparam int AW = $clog2(LS * MAX_WIDTH)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wmf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [wmf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                accept_i,
  input  wire wmf_pkg::in_item_t                   item_i,
  output logic [WB-1:0]                            w_eff_o,
  output logic [HB-1:0]                            h_eff_o,
  output logic [RB-1:0]                            r_eff_o,
  output logic                                     color_o,
  output logic                                     wr_en_o,
  output logic [AW-1:0]                            wr_addr_o,
  output logic [wmf_pkg::PIX_W-1:0]                wr_data_o,
  output logic                                     job_push_o,
  output logic [RW-1:0]                            job_oy_o,
  output logic [CW-1:0]                            job_ox_o,
  output logic [SW-1:0]                            job_slot_o,
  output logic                                     job_last_o
);
  import wmf_pkg::*;

  logic [10:0]   fw_q, fw_d;
  logic [12:0]   fh_q, fh_d;
  logic [1:0]    rad_q, rad_d;
  logic          color_q, color_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [SW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic          in_full_q, in_full_d;

  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [RB-1:0] r_eff;
  logic          pix;
  logic [WB-1:0] col_inc;
  logic [HB-1:0] row_inc;
  logic [HB:0]   ry, rx_h;
  logic [WB:0]   rx;
  logic          due;

  always_comb begin
    if (fw_q == '0) w_eff = WB'(1);
    else if (32'(fw_q) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(fw_q);
    if (fh_q == '0) h_eff = HB'(1);
    else if (32'(fh_q) > MAX_HEIGHT) h_eff = HB'(MAX_HEIGHT);
    else h_eff = HB'(fh_q);
    if (32'(rad_q) > MAX_RADIUS) r_eff = RB'(MAX_RADIUS);
    else r_eff = RB'(rad_q);
  end

  assign w_eff_o   = w_eff;
  assign h_eff_o   = h_eff;
  assign r_eff_o   = r_eff;
  assign color_o   = color_q;
  assign wr_addr_o = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign wr_data_o = {item_i.chan2, item_i.chan1, item_i.chan0};
  assign job_oy_o   = out_row_q;
  assign job_ox_o   = out_col_q;
  assign job_slot_o = out_slot_q;

  always_comb begin
    fw_d = fw_q; fh_d = fh_q; rad_d = rad_q; color_d = color_q;
    in_row_d = in_row_q; in_col_d = in_col_q; in_slot_d = in_slot_q;
    out_row_d = out_row_q; out_col_d = out_col_q; out_slot_d = out_slot_q;
    in_full_d = in_full_q;
    wr_en_o = 1'b0; job_push_o = 1'b0; job_last_o = 1'b0;
    pix = 1'b0; col_inc = '0; row_inc = '0; ry = '0; rx = '0; rx_h = '0; due = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:   fw_d = cfg_data_i[10:0];
        REG_FRAME_HEIGHT:  fh_d = cfg_data_i[12:0];
        REG_WINDOW_RADIUS: rad_d = cfg_data_i[1:0];
        REG_COLOR_MODE:    color_d = cfg_data_i[0];
        default:           fw_d = fw_q;
      endcase
      in_row_d = '0; in_col_d = '0; in_slot_d = '0;
      out_row_d = '0; out_col_d = '0; out_slot_d = '0;
      in_full_d = 1'b0;
    end else if (accept_i) begin
      pix = !item_i.flush && !in_full_q;
      if (pix) begin
        wr_en_o = 1'b1;
        col_inc = WB'(in_col_q) + WB'(1);
        if (col_inc >= w_eff) begin
          in_col_d = '0;
          row_inc = HB'(in_row_q) + HB'(1);
          if (row_inc >= h_eff) begin
            in_row_d = '0; in_slot_d = '0; in_full_d = 1'b1;
          end else begin
            in_row_d = RW'(row_inc);
            in_slot_d = (in_slot_q == SW'(LS - 1)) ? '0 : in_slot_q + SW'(1);
          end
        end else begin
          in_col_d = CW'(col_inc);
        end
      end
      // bottom-right corner of the window, clamped to the frame
      ry = (HB+1)'(out_row_q) + (HB+1)'(r_eff);
      if (ry > (HB+1)'(h_eff) - (HB+1)'(1)) ry = (HB+1)'(h_eff) - (HB+1)'(1);
      rx = (WB+1)'(out_col_q) + (WB+1)'(r_eff);
      if (rx > (WB+1)'(w_eff) - (WB+1)'(1)) rx = (WB+1)'(w_eff) - (WB+1)'(1);
      rx_h = (HB+1)'(in_row_d);
      due = in_full_d || (rx_h > ry) || ((rx_h == ry) && ((WB+1)'(in_col_d) > rx));
      if (due) begin
        job_push_o = 1'b1;
        if (WB'(out_col_q) + WB'(1) >= w_eff) begin
          out_col_d = '0;
          if (HB'(out_row_q) + HB'(1) >= h_eff) begin
            out_row_d = '0; out_slot_d = '0; job_last_o = 1'b1; in_full_d = 1'b0;
          end else begin
            out_row_d = out_row_q + RW'(1);
            out_slot_d = (out_slot_q == SW'(LS - 1)) ? '0 : out_slot_q + SW'(1);
          end
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= RST_FRAME_WIDTH; fh_q <= RST_FRAME_HEIGHT;
      rad_q <= RST_WINDOW_RADIUS; color_q <= RST_COLOR_MODE;
      in_row_q <= '0; in_col_q <= '0; in_slot_q <= '0;
      out_row_q <= '0; out_col_q <= '0; out_slot_q <= '0;
      in_full_q <= 1'b0;
    end else begin
      fw_q <= fw_d; fh_q <= fh_d; rad_q <= rad_d; color_q <= color_d;
      in_row_q <= in_row_d; in_col_q <= in_col_d; in_slot_q <= in_slot_d;
      out_row_q <= out_row_d; out_col_q <= out_col_d; out_slot_q <= out_slot_d;
      in_full_q <= in_full_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wmf_job_fifo.sv
// wmf_job_fifo: two-entry queue of window jobs between front and back
// depends on wmf_pkg only by convention
`timescale 1ns / 1ps
`default_nettype none

module wmf_job_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);
  import wmf_pkg::*;

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i && cnt_q != 2'd2) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && cnt_q != 2'd2) wptr_q <= !wptr_q;
      if (pop_i && cnt_q != 2'd0) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'((push_i && cnt_q != 2'd2) ? 1 : 0)
                     - 2'((pop_i && cnt_q != 2'd0) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

// File: hdl/wmf_back.sv
// wmf_back: line store memory, window address walk and per-channel insertion sort
// depends on wmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmf_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WB = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int HB = $clog2(MAX_HEIGHT + 1),
  localparam int RB = $clog2(MAX_RADIUS + 1),
  localparam int LS = 2 * MAX_RADIUS + 2,
  localparam int SW = $clog2(LS),
  localparam int AW = $clog2(LS * MAX_WIDTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [WB-1:0]               w_eff_i,
  input  wire logic [HB-1:0]               h_eff_i,
  input  wire logic [RB-1:0]               r_eff_i,
  input  wire logic                        color_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [wmf_pkg::PIX_W-1:0]   wr_data_i,
  input  wire logic                        job_valid_i,
  input  wire logic [RW-1:0]               job_oy_i,
  input  wire logic [CW-1:0]               job_ox_i,
  input  wire logic [SW-1:0]               job_slot_i,
  input  wire logic                        job_last_i,
  output logic                             job_pop_o,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output wmf_pkg::res_item_t               out_data_o
);
  import wmf_pkg::*;

  localparam int DEPTH = LS * MAX_WIDTH;
  localparam int SIDE  = 2 * MAX_RADIUS + 1;
  localparam int NCELL = SIDE * SIDE;
  localparam int KB    = $clog2(SIDE);
  localparam int CB    = $clog2(NCELL);
  localparam int DB    = RB + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } bk_state_e;

  bk_state_e       state_q, state_d;
  logic [RW-1:0]   oy_q, oy_d;
  logic [CW-1:0]   ox_q, ox_d;
  logic [SW-1:0]   oslot_q, oslot_d;
  logic            last_q, last_d;
  logic [KB-1:0]   dy_q, dy_d, dx_q, dx_d;
  logic            s1_valid_q, s1_valid_d, s2_valid_q;
  logic signed [DB-1:0] s1_d_q, s1_dd;
  logic [CW-1:0]   s1_x_q, s1_xd;
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] mem [DEPTH];
  logic [8:0]      cells_q [3][NCELL];
  logic [8:0]      cells_d [3][NCELL];
  logic            init_cells;
  logic            out_valid_q, out_valid_d;
  res_item_t       out_q, out_d;

  logic [KB-1:0]   side_m1;
  logic            last_issue;
  logic signed [HB+1:0] ys, ya, yc, hm1;
  logic signed [WB+1:0] xs, xa, xc, wm1;
  logic signed [SW+1:0] slot_s;
  logic [SW-1:0]   slot;
  logic [AW-1:0]   rd_addr;
  logic [CB-1:0]   mid;

  assign side_m1    = KB'({r_eff_i, 1'b0});
  assign last_issue = (dx_q == side_m1) && (dy_q == side_m1);
  assign busy_o     = (state_q == ST_READ) || (state_q == ST_DRAIN);
  assign mid        = CB'({r_eff_i, 1'b0}) * (CB'(r_eff_i) + CB'(1));

  // mirrored / clamped window coordinates, row kept as offset from the center row
  always_comb begin
    ys  = $signed((HB+2)'(oy_q)) + $signed((HB+2)'(dy_q)) - $signed((HB+2)'(r_eff_i));
    ya  = ys[HB+1] ? -ys : ys;
    hm1 = $signed((HB+2)'(h_eff_i)) - $signed((HB+2)'(1));
    yc  = (ya > hm1) ? hm1 : ya;
    s1_dd = DB'(yc - $signed((HB+2)'(oy_q)));
    xs  = $signed((WB+2)'(ox_q)) + $signed((WB+2)'(dx_q)) - $signed((WB+2)'(r_eff_i));
    xa  = xs[WB+1] ? -xs : xs;
    wm1 = $signed((WB+2)'(w_eff_i)) - $signed((WB+2)'(1));
    xc  = (xa > wm1) ? wm1 : xa;
    s1_xd = xc[CW-1:0];
  end

  always_comb begin
    slot_s = $signed((SW+2)'(oslot_q)) + (SW+2)'(s1_d_q);
    if (slot_s < 0) slot_s = slot_s + $signed((SW+2)'(LS));
    else if (slot_s >= $signed((SW+2)'(LS))) slot_s = slot_s - $signed((SW+2)'(LS));
    slot    = slot_s[SW-1:0];
    rd_addr = AW'(slot) * AW'(MAX_WIDTH) + AW'(s1_x_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (s1_valid_q) rd_q <= mem[rd_addr];
  end

  // sorted insertion, empty cells hold 256
  always_comb begin
    logic [8:0] v;
    for (int c = 0; c < 3; c++) begin
      v = {1'b0, rd_q[8*c +: 8]};
      for (int i = 0; i < NCELL; i++) begin
        cells_d[c][i] = cells_q[c][i];
        if (init_cells) begin
          cells_d[c][i] = 9'h100;
        end else if (s2_valid_q) begin
          if (i > 0 && cells_q[c][(i > 0) ? i - 1 : 0] > v)
            cells_d[c][i] = cells_q[c][(i > 0) ? i - 1 : 0];
          else if (cells_q[c][i] > v)
            cells_d[c][i] = v;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q; oy_d = oy_q; ox_d = ox_q; oslot_d = oslot_q; last_d = last_q;
    dy_d = dy_q; dx_d = dx_q; s1_valid_d = 1'b0;
    job_pop_o = 1'b0; init_cells = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1; init_cells = 1'b1;
          oy_d = job_oy_i; ox_d = job_ox_i; oslot_d = job_slot_i; last_d = job_last_i;
          dy_d = '0; dx_d = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        s1_valid_d = 1'b1;
        if (last_issue) begin
          state_d = ST_DRAIN;
        end else if (dx_q == side_m1) begin
          dx_d = '0; dy_d = dy_q + KB'(1);
        end else begin
          dx_d = dx_q + KB'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.med0 = cells_q[0][mid][7:0];
          out_d.med1 = color_i ? cells_q[1][mid][7:0] : '0;
          out_d.med2 = color_i ? cells_q[2][mid][7:0] : '0;
          out_d.frame_last = last_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    oy_q <= oy_d; ox_q <= ox_d; oslot_q <= oslot_d; last_q <= last_d;
    s1_d_q <= s1_dd; s1_x_q <= s1_xd;
    cells_q <= cells_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; dy_q <= '0; dx_q <= '0;
      s1_valid_q <= 1'b0; s2_valid_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; dy_q <= dy_d; dx_q <= dx_d;
      s1_valid_q <= s1_valid_d; s2_valid_q <= s1_valid_q; out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/window_median_filter_core.sv
// window_median_filter_core: top level of the streaming 2d median filter
// depends on wmf_pkg, wmf_front, wmf_job_fifo, wmf_back
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake                | payload
// in       | in  | in_valid_i / in_stall_o  | in_data_i  (flush, chan0..2)
// out      | out | out_valid_o / out_stall_i| out_data_o (med0..2, frame_last)
// cfg      | in  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// an item that produces no result does not stall the input; an item that produces a result
// stalls it until the back end has walked the window through the single read port of the line
// store, one window pixel per cycle
// reset is asynchronous and active low; the line store is not cleared
// a result waiting in the output register does not hold off the next item

module window_median_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire wmf_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output wmf_pkg::res_item_t                   out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wmf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [wmf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int RB = $clog2(MAX_RADIUS + 1);
  localparam int LS = 2 * MAX_RADIUS + 2;
  localparam int SW = $clog2(LS);
  localparam int AW = $clog2(LS * MAX_WIDTH);
  localparam int JW = RW + CW + SW + 1;

  logic          accept;
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [RB-1:0] r_eff;
  logic          color;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic          job_push, job_pop, fifo_empty, back_busy;
  logic [RW-1:0] f_oy, b_oy;
  logic [CW-1:0] f_ox, b_ox;
  logic [SW-1:0] f_slot, b_slot;
  logic          f_last, b_last;
  logic [JW-1:0] fifo_out;

  // config is always taken; writes must only come while the filter is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;
  // one window job in flight at a time so the line store rows it needs stay intact
  assign in_stall_o  = !fifo_empty || back_busy;
  assign accept      = in_valid_i && !in_stall_o;

  wmf_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .accept_i(accept), .item_i(in_data_i),
    .w_eff_o(w_eff), .h_eff_o(h_eff), .r_eff_o(r_eff), .color_o(color),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .job_push_o(job_push), .job_oy_o(f_oy), .job_ox_o(f_ox),
    .job_slot_o(f_slot), .job_last_o(f_last)
  );

  // job queue between classification and window evaluation
  wmf_job_fifo #(.W(JW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(job_push), .data_i({f_oy, f_ox, f_slot, f_last}),
    .pop_i(job_pop), .data_o(fifo_out), .empty_o(fifo_empty)
  );

  assign {b_oy, b_ox, b_slot, b_last} = fifo_out;

  wmf_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
  ) u_back (
    .clk_i, .rst_ni,
    .w_eff_i(w_eff), .h_eff_i(h_eff), .r_eff_i(r_eff), .color_i(color),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .job_valid_i(!fifo_empty), .job_oy_i(b_oy), .job_ox_i(b_ox),
    .job_slot_i(b_slot), .job_last_i(b_last), .job_pop_o(job_pop),
    .busy_o(back_busy),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

`default_nettype wire

// File: verif/window_median_filter_core_test.sv
// window_median_filter_core_test: self-checking testbench of the streaming 2d median filter
// depends on wmf_pkg and window_median_filter_core; a scoreboard class predicts every result
`timescale 1ns / 1ps

module window_median_filter_core_test;
  import wmf_pkg::*;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 3;
  localparam int LS_ROWS    = 2 * MAX_RADIUS + 2;
  localparam int SETTLE     = 64;   // longest busy stretch of one item, with margin
  localparam int ITEM_GOAL  = 1950;

  // predictor of the filter and store of the medians still to come
  class median_scoreboard;
    logic [PIX_W-1:0] rows [LS_ROWS*MAX_WIDTH];
    int in_row, in_col, out_row, out_col;
    bit in_full;
    int frame_width, frame_height, window_radius;
    bit color_mode;
    res_item_t medians_due[$];
    int errors;

    function new();
      frame_width   = RST_FRAME_WIDTH;
      frame_height  = RST_FRAME_HEIGHT;
      window_radius = RST_WINDOW_RADIUS;
      color_mode    = RST_COLOR_MODE;
      errors        = 0;
      restart();
    endfunction

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      in_full = 0;
    endfunction

    function int eff_w();
      return frame_width == 0 ? 1 : (frame_width > MAX_WIDTH ? MAX_WIDTH : frame_width);
    endfunction

    function int eff_h();
      return frame_height == 0 ? 1 : (frame_height > MAX_HEIGHT ? MAX_HEIGHT : frame_height);
    endfunction

    function int eff_r();
      return window_radius > MAX_RADIUS ? MAX_RADIUS : window_radius;
    endfunction

    function int frame_pixels();
      return eff_w() * eff_h();
    endfunction

    // every register write restarts the frame, the line store is kept
    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:   frame_width   = v[10:0];
        REG_FRAME_HEIGHT:  frame_height  = v[12:0];
        REG_WINDOW_RADIUS: window_radius = v[1:0];
        REG_COLOR_MODE:    color_mode    = v[0];
        default: return;
      endcase
      restart();
    endfunction

    // mirrored at top/left, clamped at bottom/right
    function logic [CH_W-1:0] median_at(int oy, int ox, int sh);
      int vals[$];
      int y, x, w, h, r;
      logic [PIX_W-1:0] px;
      w = eff_w(); h = eff_h(); r = eff_r();
      for (int dy = -r; dy <= r; dy++) begin
        y = oy + dy;
        if (y < 0) y = -y;
        if (y > h - 1) y = h - 1;
        for (int dx = -r; dx <= r; dx++) begin
          x = ox + dx;
          if (x < 0) x = -x;
          if (x > w - 1) x = w - 1;
          px = rows[(y % LS_ROWS) * MAX_WIDTH + x];
          vals.insert(vals.size(), int'((px >> sh) & 8'hff));
        end
      end
      vals.sort();
      return vals[vals.size() / 2];
    endfunction

    function void note_input(in_item_t it);
      int w, h, r, ry, rx;
      bit rdy;
      res_item_t m;
      w = eff_w(); h = eff_h(); r = eff_r();
      if (!it.flush && !in_full) begin
        rows[(in_row % LS_ROWS) * MAX_WIDTH + (in_col % MAX_WIDTH)] = {it.chan2, it.chan1, it.chan0};
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            in_row  = 0;
            in_full = 1;
          end
        end
      end
      ry = out_row + r;
      rx = out_col + r;
      if (ry > h - 1) ry = h - 1;
      if (rx > w - 1) rx = w - 1;
      rdy = in_full || in_row > ry || (in_row == ry && in_col > rx);
      if (!rdy) return;
      m.med0 = median_at(out_row, out_col, 0);
      m.med1 = color_mode ? median_at(out_row, out_col, 8) : '0;
      m.med2 = color_mode ? median_at(out_row, out_col, 16) : '0;
      m.frame_last = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) begin
          out_row      = 0;
          m.frame_last = 1'b1;
          in_full      = 0;
        end
      end
      medians_due.insert(medians_due.size(), m);
    endfunction

    function void check_result(res_item_t got);
      res_item_t m;
      if (medians_due.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      m = medians_due.pop_front();
      if (got.med0 !== m.med0) begin
        $error("med0 expected %0d actual %0d", m.med0, got.med0); errors++;
      end
      if (got.med1 !== m.med1) begin
        $error("med1 expected %0d actual %0d", m.med1, got.med1); errors++;
      end
      if (got.med2 !== m.med2) begin
        $error("med2 expected %0d actual %0d", m.med2, got.med2); errors++;
      end
      if (got.frame_last !== m.frame_last) begin
        $error("frame_last expected %0d actual %0d", m.frame_last, got.frame_last); errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  res_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  median_scoreboard medians = new();
  int  items_sent = 0;
  bit  calm = 1'b0;     // phase with neither gaps nor stalls
  int  stall_left = 0;

  window_median_filter_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side: check each accepted transaction, then draw the next stall run
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      medians.check_result(out_data_o);
      stall_left = calm ? 0 : $urandom_range(0, 8);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // one register write; valid stays high for a following write
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    medians.write_reg(idx, v);
  endtask

  // block must be idle here
  task automatic configure(int w, int h, int r, bit c);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(r));
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(c));
    cfg_valid_i <= 1'b0;
  endtask

  // one input transaction with a random lead-in gap
  task automatic send_item(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    medians.note_input(it);
    items_sent++;
  endtask

  task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    send_item('{flush: 1'b0, chan0: c0, chan1: c1, chan2: c2});
  endtask

  task automatic send_flush();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    it.flush = 1'b1;
    send_item(it);
  endtask

  // wait until every predicted median has left, then let the back end settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (medians.medians_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_chan();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // send npix pixels with flush noise, then drain the frame unless partial
  task automatic run_frame(int npix, bit partial);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 15) == 0) send_flush();
      send_pixel(random_chan(), random_chan(), random_chan());
    end
    if (!partial) begin
      // pixels after the frame is complete behave as flushes
      while (medians.in_full) begin
        if ($urandom_range(0, 3) == 0)
          send_item('{flush: 1'b0, chan0: random_chan(), chan1: random_chan(),
                      chan2: random_chan()});
        else
          send_flush();
      end
    end
    wait_idle();
  endtask

  initial begin
    int w, h, r, np, left;
    bit c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flush with nothing pending, then a 3x3 gray frame of extremes
    configure(3, 3, 1, 1'b0);
    send_flush();
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h55);
    send_pixel(8'hff, 8'haa, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h7f, 8'h01);
    send_pixel(8'h7f, 8'h80, 8'hfe);
    send_pixel(8'hff, 8'hff, 8'hff);
    // pixel after the frame is complete acts as a flush
    while (medians.in_full) send_pixel(8'hff, 8'hff, 8'hff);
    wait_idle();

    // color frame smaller than the window
    configure(2, 2, 3, 1'b1);
    send_pixel(8'h00, 8'hff, 8'h10);
    send_pixel(8'hff, 8'h00, 8'h20);
    send_pixel(8'h40, 8'h80, 8'hff);
    send_pixel(8'hc0, 8'h01, 8'h00);
    while (medians.in_full) send_flush();
    wait_idle();

    // zero width and height read as one pixel, radius zero
    configure(0, 0, 0, 1'b1);
    send_pixel(8'hff, 8'h00, 8'hff);
    while (medians.in_full) send_flush();
    send_flush();
    wait_idle();

    // widest and tallest frames, oversized values saturate, with a small calm frame between
    configure(2047, 1, 3, 1'b1);
    run_frame(medians.frame_pixels(), 1'b0);
    configure(16, 4, 1, 1'b0);
    calm = 1'b1;
    run_frame(medians.frame_pixels(), 1'b0);
    calm = 1'b0;
    configure(0, 8191, 0, 1'b0);
    run_frame(64, 1'b1);
    configure(1, 4096, 2, 1'b1);
    run_frame(64, 1'b1);

    // random frames, mostly small, some cut short before the end
    while (items_sent < ITEM_GOAL) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
      if (w > 64) h = 1;
      r = $urandom_range(0, 3);
      c = $urandom_range(0, 1);
      calm = ($urandom_range(0, 3) == 0);
      configure(w, h, r, c);
      np = medians.frame_pixels();
      left = ITEM_GOAL - items_sent;
      if (np > left)
        run_frame(left, 1'b1);
      else if ($urandom_range(0, 7) == 0)
        run_frame($urandom_range(0, np - 1), 1'b1);
      else
        run_frame(np, 1'b0);
    end
    calm = 1'b0;

    wait_idle();
    if (medians.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: window_median_filter_core.f
hdl/wmf_pkg.sv
hdl/wmf_front.sv
hdl/wmf_job_fifo.sv
hdl/wmf_back.sv
hdl/window_median_filter_core.sv
verif/window_median_filter_core_test.sv
